// ----- hdl/telnet_option_negotiator_core_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef TELNET_OPTION_NEGOTIATOR_CORE_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define TNO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TNO_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tno_pkg.sv -----
package tno_pkg;

   // telnet command codes
   localparam logic [7:0] CODE_IAC  = 8'd255;
   localparam logic [7:0] CODE_DONT = 8'd254;
   localparam logic [7:0] CODE_DO   = 8'd253;
   localparam logic [7:0] CODE_WONT = 8'd252;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_SB   = 8'd250;
   localparam logic [7:0] CODE_SE   = 8'd240;

   // config register defaults: echo, suppress go-ahead
   localparam logic [7:0] DEF_OPTION_A = 8'd1;
   localparam logic [7:0] DEF_OPTION_B = 8'd3;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_OPTION_A = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OPTION_B = 4'd1;

   // refusals buffered between parser and reply sender
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_IAC     = 3'd1,
      ST_CMD     = 3'd2,
      ST_SB      = 3'd3,
      ST_SB_DATA = 3'd4,
      ST_SB_IAC  = 3'd5
   } parse_state_type;

   // reply sender: which byte of the three-byte refusal goes out next
   typedef enum logic [1:0] {
      PH_IAC    = 2'd0,
      PH_ANSWER = 2'd1,
      PH_OPTION = 2'd2
   } reply_phase_type;

   typedef struct packed {
      logic [7:0] answer;
      logic [7:0] option;
   } refusal_type;

   typedef struct packed {
      logic        push;
      refusal_type entry;
   } push_type;

   typedef struct packed {
      logic        valid;
      refusal_type entry;
   } head_type;

endpackage

// ----- hdl/tno_front.sv -----
module tno_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic [7:0]          option_a,
   input  logic [7:0]          option_b,
   input  logic                queue_full,
   output tno_pkg::push_type   push
);

   tno_pkg::parse_state_type state_ff, state_in;
   logic [7:0]               verb_ff, verb_in;
   logic                     accept;
   logic                     known;

   // only the option byte can produce a refusal, so only it waits on the queue
   assign req_ready = !queue_full || (state_ff != tno_pkg::ST_CMD);
   assign accept    = req_valid && req_ready;
   assign known     = (req_rx_byte == option_a) || (req_rx_byte == option_b);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            tno_pkg::ST_DATA: begin
               if (req_rx_byte == tno_pkg::CODE_IAC) state_in = tno_pkg::ST_IAC;
            end
            tno_pkg::ST_IAC: begin
               priority if (req_rx_byte == tno_pkg::CODE_SB) begin
                  state_in = tno_pkg::ST_SB;
               end else if (req_rx_byte == tno_pkg::CODE_WILL ||
                            req_rx_byte == tno_pkg::CODE_WONT ||
                            req_rx_byte == tno_pkg::CODE_DO   ||
                            req_rx_byte == tno_pkg::CODE_DONT) begin
                  state_in = tno_pkg::ST_CMD;
               end else begin
                  state_in = tno_pkg::ST_DATA;
               end
            end
            tno_pkg::ST_CMD:     state_in = tno_pkg::ST_DATA;
            tno_pkg::ST_SB:      state_in = tno_pkg::ST_SB_DATA;
            tno_pkg::ST_SB_DATA: begin
               if (req_rx_byte == tno_pkg::CODE_IAC) state_in = tno_pkg::ST_SB_IAC;
            end
            tno_pkg::ST_SB_IAC: begin
               // IAC IAC keeps waiting for SE
               priority if (req_rx_byte == tno_pkg::CODE_SE) begin
                  state_in = tno_pkg::ST_DATA;
               end else if (req_rx_byte != tno_pkg::CODE_IAC) begin
                  state_in = tno_pkg::ST_SB_DATA;
               end else begin
                  state_in = tno_pkg::ST_SB_IAC;
               end
            end
            default:             state_in = tno_pkg::ST_DATA;
         endcase
      end
   end

   always_comb begin
      verb_in            = verb_ff;
      push.push          = 1'b0;
      push.entry.option  = req_rx_byte;
      push.entry.answer  = tno_pkg::CODE_DONT;
      if (accept && state_ff == tno_pkg::ST_IAC &&
          (req_rx_byte == tno_pkg::CODE_WILL || req_rx_byte == tno_pkg::CODE_WONT ||
           req_rx_byte == tno_pkg::CODE_DO   || req_rx_byte == tno_pkg::CODE_DONT)) begin
         verb_in = req_rx_byte;
      end
      if (accept && state_ff == tno_pkg::ST_CMD && !known) begin
         // DO -> WONT, WILL -> DONT; negative verbs get no reply
         if (verb_ff == tno_pkg::CODE_DO) begin
            push.push         = 1'b1;
            push.entry.answer = tno_pkg::CODE_WONT;
         end else if (verb_ff == tno_pkg::CODE_WILL) begin
            push.push         = 1'b1;
            push.entry.answer = tno_pkg::CODE_DONT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tno_pkg::ST_DATA;
         verb_ff  <= 8'd0;
      end else begin
         state_ff <= state_in;
         verb_ff  <= verb_in;
      end
   end

endmodule

// ----- hdl/tno_queue.sv -----
module tno_queue #(
   parameter int DEPTH = tno_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  tno_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output tno_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tno_pkg::refusal_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/tno_back.sv -----
module tno_back (
   input  logic              clock,
   input  logic              reset,
   input  tno_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last_of_reply
);

   tno_pkg::reply_phase_type phase_ff, phase_in;
   logic                     xfer;

   assign rsp_valid         = head.valid;
   assign xfer              = rsp_valid && rsp_ready;
   assign rsp_last_of_reply = (phase_ff == tno_pkg::PH_OPTION);
   assign pop               = xfer && rsp_last_of_reply;

   always_comb begin
      unique case (phase_ff)
         tno_pkg::PH_IAC:    rsp_tx_byte = tno_pkg::CODE_IAC;
         tno_pkg::PH_ANSWER: rsp_tx_byte = head.entry.answer;
         tno_pkg::PH_OPTION: rsp_tx_byte = head.entry.option;
         default:            rsp_tx_byte = tno_pkg::CODE_IAC;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (xfer) begin
         unique case (phase_ff)
            tno_pkg::PH_IAC:    phase_in = tno_pkg::PH_ANSWER;
            tno_pkg::PH_ANSWER: phase_in = tno_pkg::PH_OPTION;
            default:            phase_in = tno_pkg::PH_IAC;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= tno_pkg::PH_IAC;
      else       phase_ff <= phase_in;
   end

endmodule

// ----- hdl/telnet_option_negotiator_core.sv -----
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_ready | req_rx_byte[7:0]
// rsp      | out       | rsp_valid/rsp_ready | rsp_tx_byte[7:0], rsp_last_of_reply
// csr      | in        | csr_valid/csr_ready | csr_index[3:0], csr_wdata[7:0]
//
// Received bytes are taken one per cycle unless stalled; the parser decides each
// byte in the cycle it is taken. A refusal leaves as three rsp transfers, one per
// cycle unless stalled, from the reply sender reading the head of a
// QUEUE_DEPTH-entry refusal queue. req_ready drops only while the parser waits
// for an option byte and the queue is full; a stalled rsp holds the head entry
// and its byte. Reset (synchronous) returns the parser to plain data, empties the
// queue and loads the option registers with echo (1) and suppress go-ahead (3).
module telnet_option_negotiator_core #(
   parameter int QUEUE_DEPTH = tno_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_last_of_reply,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tno_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);

   // option registers; writes to unlisted indexes are dropped
   logic [7:0] option_a_ff, option_a_in;
   logic [7:0] option_b_ff, option_b_in;

   tno_pkg::push_type push;
   tno_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      option_a_in = option_a_ff;
      option_b_in = option_b_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == tno_pkg::REG_OPTION_A) option_a_in = csr_wdata;
         if (csr_index == tno_pkg::REG_OPTION_B) option_b_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         option_a_ff <= tno_pkg::DEF_OPTION_A;
         option_b_ff <= tno_pkg::DEF_OPTION_B;
      end else begin
         option_a_ff <= option_a_in;
         option_b_ff <= option_b_in;
      end
   end

   // front: parse each byte, push a refusal when an unsupported DO/WILL option lands
   tno_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .option_a    (option_a_ff),
      .option_b    (option_b_ff),
      .queue_full  (queue_full),
      .push        (push)
   );

   // queue: decouples parsing from reply transfers
   tno_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back: IAC, answer, option; pops the entry on the last transfer
   tno_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_reply (rsp_last_of_reply)
   );

endmodule

// ----- hdl/tno_checker.sv -----
`include "telnet_option_negotiator_core_defines.svh"

module tno_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [7:0]                      req_rx_byte,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_tx_byte,
   input logic                            rsp_last_of_reply,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [tno_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [7:0]                      csr_wdata
);

   // stalled reply byte holds
   `TNO_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_of_reply), "rsp payload changed while stalled")

   // a reply, once started, continues without a gap
   `TNO_ASSERT(a_rsp_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_reply |=> rsp_valid, "reply interrupted mid-burst")

   // a reply following a finished one opens with IAC
   `TNO_ASSERT(a_rsp_opens_iac, clock, reset, $past(rsp_valid && rsp_ready && rsp_last_of_reply) && rsp_valid |-> rsp_tx_byte == tno_pkg::CODE_IAC && !rsp_last_of_reply, "reply does not start with IAC")

   // nothing pending right after reset
   `TNO_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

endmodule

bind telnet_option_negotiator_core tno_checker u_tno_checker (.*);

// ----- test/telnet_option_negotiator_core_test.sv -----
`timescale 1ns / 100ps

module telnet_option_negotiator_core_test;

   localparam int STALL_MAX        = 10;
   localparam int SETTLE_CYCLES    = 20;    // parser decides per byte, refusal drains as 3 beats
   localparam int LONG_HOLD_CYCLES = 150;   // receiver hold-off that backs up the refusal queue
   localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no transfer on any channel
   localparam int REPORT_MAX       = 10;
   localparam int DIRECTED_COUNT   = 28;

   // How a directed row is checked: by the predictor, or against a typed-in outcome.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_WONT,
      ROW_DONT
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   rx_byte;
      row_kind_type kind;
   } table_row_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_of_reply;
   } reply_beat_type;

   logic                            clock;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_rx_byte       = 8'd0;
   row_kind_type                    req_kind          = ROW_PREDICT;  // rides with the payload
   logic                            rsp_valid;
   logic                            rsp_ready         = 1'b0;
   logic [7:0]                      rsp_tx_byte;
   logic                            rsp_last_of_reply;
   logic                            csr_valid         = 1'b0;
   logic                            csr_ready;
   logic [tno_pkg::CSR_INDEX_W-1:0] csr_index         = tno_pkg::REG_OPTION_A;
   logic [7:0]                      csr_wdata         = 8'd0;

   // predictor state, advanced on every req transfer
   tno_pkg::parse_state_type parser_state = tno_pkg::ST_DATA;
   logic [7:0]               pending_verb = 8'd0;
   logic [7:0]               known_a      = tno_pkg::DEF_OPTION_A;
   logic [7:0]               known_b      = tno_pkg::DEF_OPTION_B;
   reply_beat_type           replies_due [$];

   // stimulus side copy of the option registers, used to aim at supported options
   logic [7:0] cfg_a = tno_pkg::DEF_OPTION_A;
   logic [7:0] cfg_b = tno_pkg::DEF_OPTION_B;
   logic [7:0] plan [$];

   bit idle_free    = 1'b0;  // both sides run without gaps while set
   bit hold_request = 1'b0;  // asks the receiver for one long hold-off
   int error_count  = 0;
   int quiet_cycles = 0;

   // Directed bytes. Option rows under the reset registers (echo, suppress go-ahead)
   // and the first data byte carry their outcome; the rest go through the predictor.
   table_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h00,              ROW_SILENT},   // plain data right after reset
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},  // escaped IAC, back to data
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_DO,   ROW_PREDICT},
      '{8'h00,              ROW_WONT},     // unsupported option 0 after DO
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_WILL, ROW_PREDICT},
      '{8'hFF,              ROW_DONT},     // option 255 after WILL
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_DO,   ROW_PREDICT},
      '{8'h01,              ROW_SILENT},   // echo is supported
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_DONT, ROW_PREDICT},
      '{8'h05,              ROW_PREDICT},
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_WONT, ROW_PREDICT},
      '{8'h07,              ROW_PREDICT},
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{8'hF1,              ROW_PREDICT},  // unknown command after IAC
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_SB,   ROW_PREDICT},
      '{8'hFF,              ROW_PREDICT},  // subnegotiation option byte, not examined
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{8'h05,              ROW_PREDICT},  // other byte after IAC, back to subneg data
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},
      '{tno_pkg::CODE_IAC,  ROW_PREDICT},  // IAC IAC stays in IAC-in-subneg
      '{tno_pkg::CODE_SE,   ROW_PREDICT}   // so SE closes the subnegotiation
   };

   telnet_option_negotiator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_reply (rsp_last_of_reply),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endfunction

   // One parser step: refuse is set when the byte is an option after DO/WILL that
   // neither register accepts; answer is the refusal verb to send back.
   function automatic void negotiate_byte(input logic [7:0] c, output bit refuse,
                                          output logic [7:0] answer);
      refuse = 1'b0;
      answer = tno_pkg::CODE_WONT;
      case (parser_state)
         tno_pkg::ST_DATA: begin
            if (c == tno_pkg::CODE_IAC) parser_state = tno_pkg::ST_IAC;
         end
         tno_pkg::ST_IAC: begin
            if (c == tno_pkg::CODE_SB) begin
               parser_state = tno_pkg::ST_SB;
            end else if (c == tno_pkg::CODE_WILL || c == tno_pkg::CODE_WONT ||
                         c == tno_pkg::CODE_DO   || c == tno_pkg::CODE_DONT) begin
               pending_verb = c;
               parser_state = tno_pkg::ST_CMD;
            end else begin
               parser_state = tno_pkg::ST_DATA;
            end
         end
         tno_pkg::ST_CMD: begin
            if (c != known_a && c != known_b) begin
               if (pending_verb == tno_pkg::CODE_DO) begin
                  refuse = 1'b1;
                  answer = tno_pkg::CODE_WONT;
               end else if (pending_verb == tno_pkg::CODE_WILL) begin
                  refuse = 1'b1;
                  answer = tno_pkg::CODE_DONT;
               end
            end
            parser_state = tno_pkg::ST_DATA;
         end
         tno_pkg::ST_SB: parser_state = tno_pkg::ST_SB_DATA;
         tno_pkg::ST_SB_DATA: begin
            if (c == tno_pkg::CODE_IAC) parser_state = tno_pkg::ST_SB_IAC;
         end
         tno_pkg::ST_SB_IAC: begin
            if (c == tno_pkg::CODE_SE) parser_state = tno_pkg::ST_DATA;
            else if (c != tno_pkg::CODE_IAC) parser_state = tno_pkg::ST_SB_DATA;
         end
         default: parser_state = tno_pkg::ST_DATA;
      endcase
   endfunction

   function automatic void queue_refusal(input logic [7:0] answer, input logic [7:0] option);
      replies_due.push_back('{tno_pkg::CODE_IAC, 1'b0});
      replies_due.push_back('{answer, 1'b0});
      replies_due.push_back('{option, 1'b1});
   endfunction

   // Transfers are sampled right at the edge, before any NBA of this step lands.
   always @(posedge clock) begin : reply_check
      reply_beat_type due;
      bit             refuse;
      logic [7:0]     answer;
      if (reset) begin
         parser_state = tno_pkg::ST_DATA;
         pending_verb = 8'd0;
         known_a      = tno_pkg::DEF_OPTION_A;
         known_b      = tno_pkg::DEF_OPTION_B;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tno_pkg::REG_OPTION_A) known_a = csr_wdata;
            else if (csr_index == tno_pkg::REG_OPTION_B) known_b = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               flag_error($sformatf("unexpected reply byte %0d last %0d",
                                    rsp_tx_byte, rsp_last_of_reply));
            end else begin
               due = replies_due.pop_front();
               if (rsp_tx_byte !== due.tx_byte)
                  flag_error($sformatf("tx_byte expected %0d got %0d",
                                       due.tx_byte, rsp_tx_byte));
               if (rsp_last_of_reply !== due.last_of_reply)
                  flag_error($sformatf("last_of_reply expected %0d got %0d",
                                       due.last_of_reply, rsp_last_of_reply));
            end
         end
         if (req_valid && req_ready) begin
            negotiate_byte(req_rx_byte, refuse, answer);
            case (req_kind)
               ROW_PREDICT: begin
                  if (refuse) queue_refusal(answer, req_rx_byte);
               end
               ROW_WONT: queue_refusal(tno_pkg::CODE_WONT, req_rx_byte);
               ROW_DONT: queue_refusal(tno_pkg::CODE_DONT, req_rx_byte);
               default: ;
            endcase
         end
      end
   end

   // Watchdog: any transfer resets the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stall before each beat, or one long hold-off on request.
   initial begin : receiver
      int stall;
      forever begin
         if (hold_request) begin
            stall = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = idle_free ? 0 : $urandom_range(STALL_MAX);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Sender: optional gap, then hold valid and payload until the transfer.
   // With no gap, valid is only raised again, never dropped in the same step.
   task automatic send_byte(input logic [7:0] value, input row_kind_type kind);
      int gap;
      gap = idle_free ? 0 : $urandom_range(STALL_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      req_kind    <= kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Quiet the input, wait out all refusals, then let the block settle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [tno_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_options(input logic [7:0] option_a, input logic [7:0] option_b);
      settle();
      write_register(tno_pkg::REG_OPTION_A, option_a);
      write_register(tno_pkg::REG_OPTION_B, option_b);
      csr_valid <= 1'b0;
      cfg_a = option_a;
      cfg_b = option_b;
   endtask

   // Mostly well formed telnet sequences with random content, some noise.
   function automatic void plan_sequence();
      logic [7:0] verbs [4];
      int         pick;
      int         len;
      verbs = '{tno_pkg::CODE_WILL, tno_pkg::CODE_WONT, tno_pkg::CODE_DO, tno_pkg::CODE_DONT};
      pick  = $urandom_range(99);
      if (pick < 45) begin
         // option command, aimed at a supported option half the time
         plan.push_back(tno_pkg::CODE_IAC);
         plan.push_back(verbs[$urandom_range(3)]);
         case ($urandom_range(3))
            0: plan.push_back(cfg_a);
            1: plan.push_back(cfg_b);
            default: plan.push_back(8'($urandom_range(255)));
         endcase
      end else if (pick < 60) begin
         len = $urandom_range(4, 1);
         repeat (len) plan.push_back(8'($urandom_range(254)));
      end else if (pick < 68) begin
         plan.push_back(tno_pkg::CODE_IAC);
         plan.push_back(tno_pkg::CODE_IAC);
      end else if (pick < 82) begin
         // subnegotiation; body bytes may carry IACs of their own
         plan.push_back(tno_pkg::CODE_IAC);
         plan.push_back(tno_pkg::CODE_SB);
         plan.push_back(8'($urandom_range(255)));
         len = $urandom_range(4);
         repeat (len) begin
            plan.push_back($urandom_range(3) == 0 ? tno_pkg::CODE_IAC
                                                  : 8'($urandom_range(255)));
         end
         plan.push_back(tno_pkg::CODE_IAC);
         plan.push_back(tno_pkg::CODE_SE);
      end else if (pick < 90) begin
         plan.push_back(tno_pkg::CODE_IAC);
         plan.push_back(8'($urandom_range(255)));
      end else begin
         plan.push_back(8'($urandom_range(255)));
      end
   endfunction

   task automatic run_random(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         plan_sequence();
         while (plan.size() != 0) begin
            send_byte(plan.pop_front(), ROW_PREDICT);
            sent++;
         end
      end
   endtask

   // Back-to-back refusals while the receiver holds off: the queue fills and
   // req_ready has to drop on an option byte.
   task automatic flood_refusals(input int count);
      logic [7:0] option;
      idle_free    = 1'b1;
      hold_request = 1'b1;
      repeat (count) begin
         option = 8'($urandom_range(255));
         while (option == cfg_a || option == cfg_b) option = 8'($urandom_range(255));
         send_byte(tno_pkg::CODE_IAC, ROW_PREDICT);
         send_byte($urandom_range(1) ? tno_pkg::CODE_DO : tno_pkg::CODE_WILL, ROW_PREDICT);
         send_byte(option, ROW_PREDICT);
      end
      idle_free = 1'b0;
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_byte(directed_rows[i].rx_byte, directed_rows[i].kind);
      run_random(60);
      idle_free = 1'b1;
      run_random(40);
      idle_free = 1'b0;

      // register extremes
      set_options(8'h00, 8'hFF);
      run_random(80);
      set_options(8'hFF, 8'h00);
      flood_refusals(16);
      run_random(60);

      // both registers naming one option
      set_options(8'h18, 8'h18);
      run_random(80);

      set_options(8'($urandom_range(255)), 8'($urandom_range(255)));
      idle_free = 1'b1;
      run_random(30);
      idle_free = 1'b0;
      run_random(50);

      settle();
      if (error_count == 0 && replies_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tno_pkg.sv
hdl/tno_front.sv
hdl/tno_queue.sv
hdl/tno_back.sv
hdl/telnet_option_negotiator_core.sv
hdl/tno_checker.sv
test/telnet_option_negotiator_core_test.sv
